[src/lcfl_pkg.sv]
// Shared types, constants and the control store for the load cell filter and linearizer.
// Used by the channel interfaces and by every module of the block. No dependencies.
`default_nettype none

package lcfl_pkg;

   localparam int RAW_W     = 24;  // converter count and smoothed count
   localparam int COEF_W    = 32;  // signed Q8.24 coefficients
   localparam int FORCE_W   = 37;  // signed Q12.24 force
   localparam int FRAC_BITS = 23;  // magnitude is Q0.23 of full scale
   localparam int MAG_BITS  = 24;  // magnitude reaches 2^23 exactly
   localparam int ACC_W     = 35;  // Horner accumulator, bounded by the coefficient sum
   localparam int CSR_IDX_W = 3;
   localparam int PC_W      = 3;
   localparam int CNT_W     = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TENSION_C0  = 3'd0,
      REG_TENSION_C1  = 3'd1,
      REG_TENSION_C2  = 3'd2,
      REG_TENSION_C3  = 3'd3,
      REG_COMPRESS_C0 = 3'd4,
      REG_COMPRESS_C1 = 3'd5,
      REG_COMPRESS_C2 = 3'd6,
      REG_COMPRESS_C3 = 3'd7
   } reg_idx_type;

   // Datapath operations, one per control word.
   typedef enum logic [2:0] {
      OP_IDLE = 3'd0,  // wait for a request beat and capture it
      OP_FILT = 3'd1,  // weighted sum of old smoothed value and new count
      OP_DMUL = 3'd2,  // magnitude times reciprocal of the divisor
      OP_DQ   = 3'd3,  // quotient estimate and remainder
      OP_DFIX = 3'd4,  // quotient correction, sign, bank select, load c3
      OP_HMUL = 3'd5,  // accumulator times magnitude
      OP_HADD = 3'd6,  // floor scale and add next coefficient
      OP_OUT  = 3'd7   // negate, clamp and load the response register
   } op_type;

   typedef enum logic [1:0] {
      JC_NEXT     = 2'd0,  // always fall through
      JC_WAIT_REQ = 2'd1,  // hold until a request is present
      JC_LOOP     = 2'd2,  // jump to target while coefficients remain
      JC_WAIT_OUT = 2'd3   // jump to target once the response slot is free
   } jc_type;

   typedef logic [PC_W-1:0] pc_type;

   typedef struct packed {
      op_type op;
      jc_type jc;
      pc_type target;
   } ucw_type;

   // Control from sequencer to datapath.
   typedef struct packed {
      op_type           op;
      logic [CNT_W-1:0] cnt;
   } ctrl_type;

   // Status from datapath back to the sequencer.
   typedef struct packed {
      logic req_valid;
      logic out_free;
   } stat_type;

   localparam pc_type PC_IDLE = 3'd0;
   localparam pc_type PC_FILT = 3'd1;
   localparam pc_type PC_DMUL = 3'd2;
   localparam pc_type PC_DQ   = 3'd3;
   localparam pc_type PC_DFIX = 3'd4;
   localparam pc_type PC_HMUL = 3'd5;
   localparam pc_type PC_HADD = 3'd6;
   localparam pc_type PC_OUT  = 3'd7;

   function automatic ucw_type ucode_rom(input pc_type pc);
      ucw_type w;
      w = '{op: OP_IDLE, jc: JC_WAIT_REQ, target: PC_IDLE};
      case (pc)
         PC_IDLE: w = '{op: OP_IDLE, jc: JC_WAIT_REQ, target: PC_FILT};
         PC_FILT: w = '{op: OP_FILT, jc: JC_NEXT,     target: PC_DMUL};
         PC_DMUL: w = '{op: OP_DMUL, jc: JC_NEXT,     target: PC_DQ};
         PC_DQ:   w = '{op: OP_DQ,   jc: JC_NEXT,     target: PC_DFIX};
         PC_DFIX: w = '{op: OP_DFIX, jc: JC_NEXT,     target: PC_HMUL};
         PC_HMUL: w = '{op: OP_HMUL, jc: JC_NEXT,     target: PC_HADD};
         PC_HADD: w = '{op: OP_HADD, jc: JC_LOOP,     target: PC_HMUL};
         PC_OUT:  w = '{op: OP_OUT,  jc: JC_WAIT_OUT, target: PC_IDLE};
         default: w = '{op: OP_IDLE, jc: JC_WAIT_REQ, target: PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

[src/lcfl_if.sv]
// Channel interfaces of the load cell filter and linearizer: request, response, register write.
// Depends on lcfl_pkg for the field widths.
`default_nettype none

interface lcfl_req_if;
   import lcfl_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [RAW_W-1:0] raw_count;
   logic                    mode;
   modport source (output valid, raw_count, mode, input ready);
   modport sink   (input valid, raw_count, mode, output ready);
endinterface

interface lcfl_rsp_if;
   import lcfl_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [RAW_W-1:0]   filtered_count;
   logic signed [FORCE_W-1:0] force_res;
   logic                      saturated;
   modport source (output valid, filtered_count, force_res, saturated, input ready);
   modport sink   (input valid, filtered_count, force_res, saturated, output ready);
endinterface

interface lcfl_csr_if;
   import lcfl_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COEF_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/lcfl_coef_regs.sv]
// Coefficient register file: eight signed Q8.24 words written through the register channel.
// Depends on lcfl_pkg and lcfl_csr_if.
`default_nettype none

module lcfl_coef_regs (
   input  wire logic                            clock,
   input  wire logic                            reset,
   lcfl_csr_if.sink                             csr_ch,
   input  wire logic [lcfl_pkg::CSR_IDX_W-1:0]  coef_idx,
   output logic signed [lcfl_pkg::COEF_W-1:0]   coef
);
   import lcfl_pkg::*;

   localparam int NUM_REGS = 2 ** CSR_IDX_W;

   logic signed [COEF_W-1:0] coef_ff [NUM_REGS];

   assign csr_ch.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_ch.valid) begin
         coef_ff[csr_ch.index] <= signed'(csr_ch.data);
      end
   end

   assign coef = coef_ff[coef_idx];

endmodule

`default_nettype wire

[src/lcfl_sequencer.sv]
// Microcode sequencer: step counter, control store lookup, coefficient loop counter.
// Depends on lcfl_pkg for the control word layout and the program.
`default_nettype none

module lcfl_sequencer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lcfl_pkg::stat_type stat,
   output lcfl_pkg::ctrl_type      ctrl
);
   import lcfl_pkg::*;

   pc_type           pc_ff, pc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   ucw_type          word;

   assign word = ucode_rom(pc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= PC_IDLE;
         cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      pc_in  = pc_ff + pc_type'(1);
      cnt_in = cnt_ff;
      case (word.jc)
         JC_NEXT:     pc_in = pc_ff + pc_type'(1);
         JC_WAIT_REQ: pc_in = stat.req_valid ? word.target : pc_ff;
         JC_LOOP:     pc_in = (cnt_ff != '0) ? word.target : pc_ff + pc_type'(1);
         JC_WAIT_OUT: pc_in = stat.out_free ? word.target : pc_ff;
         default:     pc_in = pc_ff + pc_type'(1);
      endcase
      // c3 is loaded at the fix-up step, then c2, c1 and c0 are added in turn.
      if (word.op == OP_DFIX) begin
         cnt_in = CNT_W'(2);
      end else if (word.op == OP_HADD && cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   assign ctrl.op  = word.op;
   assign ctrl.cnt = cnt_ff;

   a_cnt_load: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_DFIX) |=> (cnt_ff == CNT_W'(2)))
      else $error("coefficient counter not loaded at fix-up step");

   a_loop_back: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_HADD && cnt_ff != '0) |=> (ctrl.op == OP_HMUL))
      else $error("Horner loop did not repeat");

   a_loop_exit: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_HADD && cnt_ff == '0) |=> (ctrl.op == OP_OUT))
      else $error("Horner loop did not exit to output step");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_OUT && !stat.out_free) |=> (ctrl.op == OP_OUT))
      else $error("output step left while response slot busy");

endmodule

`default_nettype wire

[src/lcfl_datapath.sv]
// Datapath: filter, constant divide by reciprocal, shared multiplier for Horner, clamp, response.
// Depends on lcfl_pkg, lcfl_req_if and lcfl_rsp_if; driven by lcfl_sequencer.
`default_nettype none

module lcfl_datapath #(
   parameter int FILTER_WEIGHT = 5
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire lcfl_pkg::ctrl_type              ctrl,
   output lcfl_pkg::stat_type                   stat,
   lcfl_req_if.sink                             req_ch,
   lcfl_rsp_if.source                           rsp_ch,
   output logic [lcfl_pkg::CSR_IDX_W-1:0]       coef_idx,
   input  wire logic signed [lcfl_pkg::COEF_W-1:0] coef
);
   import lcfl_pkg::*;

   // |W*s + raw| <= (W+1)*2^23, so this many bits hold the magnitude.
   localparam int MAG_W   = RAW_W + $clog2(FILTER_WEIGHT + 1);
   localparam int FACC_W  = MAG_W + 1;
   localparam int MUL_A_W = (ACC_W > MAG_W + 1) ? ACC_W : MAG_W + 1;
   localparam int MUL_B_W = (MAG_BITS + 1 > MAG_W + 1) ? MAG_BITS + 1 : MAG_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int FW      = FORCE_W + 1;

   localparam logic signed [FACC_W-1:0] WEIGHT = FACC_W'(FILTER_WEIGHT);
   localparam logic [MAG_W-1:0]         DIV    = MAG_W'(FILTER_WEIGHT + 1);
   // floor(2^MAG_W / DIV): the estimate is the true quotient or one below it.
   localparam logic [MAG_W-1:0]         RECIP  =
      MAG_W'((64'd1 << MAG_W) / (FILTER_WEIGHT + 1));
   localparam logic signed [FW-1:0]     FMAX   = (FW'(1) << (FORCE_W - 1)) - FW'(1);
   localparam logic signed [FW-1:0]     FMIN   = -(FW'(1) << (FORCE_W - 1));

   logic signed [RAW_W-1:0]   raw_ff;
   logic                      mode_ff;
   logic                      fneg_ff;
   logic [MAG_W-1:0]          fmag_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [MAG_BITS-1:0]       q0_ff;
   logic [MAG_W-1:0]          rem_ff;
   logic signed [RAW_W-1:0]   smoothed_ff, smoothed_in;
   logic [MAG_BITS-1:0]       mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      rsp_valid_ff;
   logic signed [RAW_W-1:0]   rsp_filt_ff;
   logic signed [FORCE_W-1:0] rsp_force_ff;
   logic                      rsp_sat_ff;

   logic signed [FACC_W-1:0]  facc;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic signed [PROD_W-1:0]  prod_scaled;
   logic [MAG_BITS-1:0]       q0;
   logic [MAG_W-1:0]          qd;
   logic [MAG_BITS-1:0]       q;
   logic signed [FW-1:0]      force_w;
   logic                      sat;
   logic                      req_take;
   logic                      out_free;
   logic [CSR_IDX_W-1:0]      bank_base;
   logic [CNT_W-1:0]          coef_k;

   assign req_ch.ready = (ctrl.op == OP_IDLE) && !reset;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign stat.req_valid = req_ch.valid;
   assign stat.out_free  = out_free;

   assign facc = WEIGHT * FACC_W'(smoothed_ff) + FACC_W'(raw_ff);

   // Quotient estimate and its remainder, both taken from the product register.
   assign q0 = prod_ff[MAG_W +: MAG_BITS];
   assign qd = MAG_W'({{(MAG_W - MAG_BITS){1'b0}}, q0} * DIV);

   // Quotient correction; the smoothed magnitude equals the quotient.
   assign q  = q0_ff + MAG_BITS'(rem_ff >= DIV);
   assign smoothed_in = fneg_ff ? -RAW_W'(q) : RAW_W'(q);
   assign mag_in      = q;
   // Zero argument always takes the tension bank without negation.
   assign neg_in      = (q != '0) && (mode_ff || fneg_ff);

   always_comb begin
      bank_base = (ctrl.op == OP_DFIX ? neg_in : neg_ff) ? REG_COMPRESS_C0 : REG_TENSION_C0;
      coef_k    = (ctrl.op == OP_DFIX) ? CNT_W'(3) : ctrl.cnt;
      coef_idx  = bank_base | CSR_IDX_W'(coef_k);
   end

   // One shared multiplier: reciprocal divide, then the three Horner products.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.op)
         OP_DMUL: begin
            mul_a = MUL_A_W'(fmag_ff);
            mul_b = MUL_B_W'(RECIP);
         end
         OP_HMUL: begin
            mul_a = MUL_A_W'(acc_ff);
            mul_b = MUL_B_W'(mag_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod        = mul_a * mul_b;
   assign prod_scaled = prod_ff >>> FRAC_BITS;  // arithmetic shift rounds toward minus infinity

   always_comb begin
      acc_in = acc_ff;
      case (ctrl.op)
         OP_DFIX: acc_in = ACC_W'(coef);
         OP_HADD: acc_in = ACC_W'(prod_scaled) + ACC_W'(coef);
         default: acc_in = acc_ff;
      endcase
   end

   always_comb begin
      force_w = neg_ff ? -FW'(acc_ff) : FW'(acc_ff);
      sat     = (force_w > FMAX) || (force_w < FMIN);
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         raw_ff  <= req_ch.raw_count;
         mode_ff <= req_ch.mode;
      end
      if (ctrl.op == OP_FILT) begin
         fneg_ff <= facc[FACC_W-1];
         fmag_ff <= facc[FACC_W-1] ? MAG_W'(-facc) : MAG_W'(facc);
      end
      if (ctrl.op == OP_DMUL || ctrl.op == OP_HMUL) begin
         prod_ff <= prod;
      end
      if (ctrl.op == OP_DQ) begin
         q0_ff  <= q0;
         rem_ff <= fmag_ff - qd;
      end
      if (ctrl.op == OP_DFIX) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
      acc_ff <= acc_in;
      if (ctrl.op == OP_OUT && out_free) begin
         rsp_filt_ff  <= smoothed_ff;
         rsp_force_ff <= sat ? (force_w > FMAX ? FORCE_W'(FMAX) : FORCE_W'(FMIN))
                             : FORCE_W'(force_w);
         rsp_sat_ff   <= sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smoothed_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.op == OP_DFIX) begin
            smoothed_ff <= smoothed_in;
         end
         if (ctrl.op == OP_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.filtered_count = rsp_filt_ff;
   assign rsp_ch.force_res      = rsp_force_ff;
   assign rsp_ch.saturated      = rsp_sat_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.op == OP_OUT))
      else $error("response raised outside the output step");

   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_HMUL) |-> (mag_ff <= (MAG_BITS'(1) << FRAC_BITS)))
      else $error("Horner magnitude above full scale");

   a_zero_tension: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_HMUL && mag_ff == '0) |-> !neg_ff)
      else $error("zero argument routed to compression bank");

endmodule

`default_nettype wire

[src/load_cell_filter_linearizer.sv]
// Load cell filter and cubic linearizer, top level.
// Request channel req_ch carries a signed 24-bit converter count and a mode bit
// (1 forces the compression side). Response channel rsp_ch returns the new
// smoothed count, the linearized force in signed Q12.24 and a clamp flag, one
// response beat per request beat, in order. Register channel csr_ch writes the
// eight signed Q8.24 coefficients: indexes 0 to 3 are tension c0..c3, 4 to 7
// compression c0..c3; it is ready whenever reset is low. The user must write it only
// while idle; the block itself does not enforce this. A request is taken in the
// sequencer's wait step. The response register loads in the output step, after
// four steps for the filter and its divide by the filter weight plus one and
// three multiply/add pairs on the one shared multiplier. A new request is taken
// once that step completes; each item finishes before the next. When the receiver
// stalls, the finished result waits in the response register, the next item is
// still accepted and computed, and the sequencer holds in its output step until
// the register is taken. Reset clears the smoothed count, all coefficients, the
// response valid flag and returns the sequencer to its wait step; no channel
// accepts a beat while reset is high.
// Depends on lcfl_pkg, the channel interfaces and the three submodules.
`default_nettype none

module load_cell_filter_linearizer #(
   parameter int FILTER_WEIGHT = 5
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lcfl_req_if.sink   req_ch,
   lcfl_rsp_if.source rsp_ch,
   lcfl_csr_if.sink   csr_ch
);
   import lcfl_pkg::*;

   ctrl_type                 ctrl;
   stat_type                 stat;
   logic [CSR_IDX_W-1:0]     coef_idx;
   logic signed [COEF_W-1:0] coef;

   lcfl_coef_regs u_coef_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_ch   (csr_ch),
      .coef_idx (coef_idx),
      .coef     (coef)
   );

   lcfl_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   lcfl_datapath #(
      .FILTER_WEIGHT (FILTER_WEIGHT)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .stat     (stat),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .coef_idx (coef_idx),
      .coef     (coef)
   );

endmodule

`default_nettype wire
